FILE: rtl/core/tbp_pkg.sv
package tbp_pkg;

    // Branch address width, fixed by the port
    localparam int PC_BITS = 48;
    // Width of each statistics field on the result port
    localparam int STAT_BITS = 32;

    localparam int DEF_TABLE_ENTRIES = 1024;
    localparam int DEF_COUNT_BITS    = 32;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 48;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_HIGH = 1'b1;

    // Starting values for an entry seen for the first time
    localparam logic [1:0] CTR_INIT = 2'd2;
    localparam logic [1:0] SEL_INIT = 2'd2;
    localparam logic [1:0] SAT2_MAX = 2'd3;
    localparam logic [1:0] SAT2_MIN = 2'd0;

    // Classified branch, front to back
    typedef struct packed {
        logic               in_range;
        logic               taken;
        logic [PC_BITS-1:0] pc;
    } item_t;

    // Per-branch prediction flags of one result beat
    typedef struct packed {
        logic in_range;
        logic pred_last;
        logic pred_counter;
        logic pred_chosen;
        logic chosen_miss;
    } result_t;

endpackage

FILE: rtl/core/tbp_ram.sv
module tbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/tbp_front.sv
module tbp_front import tbp_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PC_BITS-1:0]       s_branch_pc,
    input  logic                     s_taken,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // queue to back end
    input  logic                     clear_busy,
    output logic                     q_valid,
    output item_t                    q_item,
    input  logic                     q_pop
);

    localparam int QDEPTH = 2;

    logic [PC_BITS-1:0] range_low_reg, range_low_next;
    logic [PC_BITS-1:0] range_high_reg, range_high_next;

    item_t       q_data_reg [QDEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    logic  push;
    item_t push_item;

    always_comb begin
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_RANGE_LOW:  range_low_next  = cfg_wdata[PC_BITS-1:0];
                REG_RANGE_HIGH: range_high_next = cfg_wdata[PC_BITS-1:0];
                default: ;
            endcase
        end
    end

    // classify: inverted range gives nothing in range
    assign push_item.in_range = (s_branch_pc >= range_low_reg) &&
                                (s_branch_pc <= range_high_reg);
    assign push_item.taken    = s_taken;
    assign push_item.pc       = s_branch_pc;

    assign s_ready = (count_reg != 2'(QDEPTH)) && !clear_busy;
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_data_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg  <= '0;
            range_high_reg <= '1;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
        end else begin
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_data_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/core/tbp_back.sv
module tbp_back import tbp_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // queue from front end
    input  logic                  q_valid,
    input  item_t                 q_item,
    output logic                  q_pop,
    output logic                  clear_busy,
    // result register
    output logic                  m_valid,
    input  logic                  m_ready,
    output result_t               res,
    output logic [COUNT_BITS-1:0] total_cnt,
    output logic [COUNT_BITS-1:0] taken_cnt,
    output logic [COUNT_BITS-1:0] last_cnt,
    output logic [COUNT_BITS-1:0] ctr_cnt,
    output logic [COUNT_BITS-1:0] chosen_cnt
);

    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);
    localparam int TAG_BITS = PC_BITS - IDX_BITS;
    // entry: valid | tag | last | counter[1:0] | chooser[1:0]
    localparam int ENTRY_W  = TAG_BITS + 6;
    localparam int POS_LAST = 4;
    localparam int POS_TAG  = 5;
    localparam int POS_VLD  = ENTRY_W - 1;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   clr_idx_reg, clr_idx_next;
    item_t                 item_reg, item_next;
    logic                  m_valid_reg, m_valid_next;
    result_t               res_reg, res_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [COUNT_BITS-1:0] taken_reg, taken_next;
    logic [COUNT_BITS-1:0] last_reg, last_next;
    logic [COUNT_BITS-1:0] ctr_reg, ctr_next;
    logic [COUNT_BITS-1:0] chosen_reg, chosen_next;

    logic                  ram_we, ram_re;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

    logic [TAG_BITS-1:0]   item_tag;
    logic                  hit, p_last, p_cnt, p_hyb, miss, out_free;
    logic [1:0]            cnt_cur, sel_cur, cnt_new, sel_new;

    tbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (q_item.pc[IDX_BITS-1:0]),
        .rd_data (ram_rdata)
    );

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                      input logic en);
        sat_inc = (en && (v != '1)) ? v + COUNT_BITS'(1) : v;
    endfunction

    assign item_tag = item_reg.pc[PC_BITS-1:IDX_BITS];
    assign hit      = ram_rdata[POS_VLD] &&
                      (ram_rdata[POS_TAG +: TAG_BITS] == item_tag);
    assign cnt_cur  = hit ? ram_rdata[3:2] : CTR_INIT;
    assign sel_cur  = hit ? ram_rdata[1:0] : SEL_INIT;
    assign p_last   = hit ? ram_rdata[POS_LAST] : item_reg.taken;
    assign p_cnt    = cnt_cur[1];
    assign p_hyb    = sel_cur[1] ? p_cnt : p_last;
    assign miss     = p_hyb ^ item_reg.taken;

    always_comb begin
        sel_new = sel_cur;
        if (hit && (p_last != p_cnt)) begin
            if (p_cnt == item_reg.taken) begin
                if (sel_cur != SAT2_MAX) sel_new = sel_cur + 2'd1;
            end else begin
                if (sel_cur != SAT2_MIN) sel_new = sel_cur - 2'd1;
            end
        end
        cnt_new = cnt_cur;
        if (item_reg.taken) begin
            if (cnt_cur != SAT2_MAX) cnt_new = cnt_cur + 2'd1;
        end else begin
            if (cnt_cur != SAT2_MIN) cnt_new = cnt_cur - 2'd1;
        end
    end

    // result slot frees this cycle if empty or being taken
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        item_next    = item_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        total_next   = total_reg;
        taken_next   = taken_reg;
        last_next    = last_reg;
        ctr_next     = ctr_reg;
        chosen_next  = chosen_reg;
        q_pop        = 1'b0;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = item_reg.pc[IDX_BITS-1:0];
        ram_wdata    = {1'b1, item_tag, item_reg.taken, cnt_new, sel_new};
        case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + IDX_BITS'(1);
                if (clr_idx_reg == LAST_IDX) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    ram_re     = 1'b1;
                    item_next  = q_item;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (item_reg.in_range) begin
                        ram_we      = 1'b1;
                        res_next    = '{in_range: 1'b1, pred_last: p_last,
                                        pred_counter: p_cnt, pred_chosen: p_hyb,
                                        chosen_miss: miss};
                        total_next  = sat_inc(total_reg, 1'b1);
                        taken_next  = sat_inc(taken_reg, item_reg.taken);
                        last_next   = sat_inc(last_reg, p_last == item_reg.taken);
                        ctr_next    = sat_inc(ctr_reg, p_cnt == item_reg.taken);
                        chosen_next = sat_inc(chosen_reg, !miss);
                    end else begin
                        res_next = '0;
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
            total_reg   <= '0;
            taken_reg   <= '0;
            last_reg    <= '0;
            ctr_reg     <= '0;
            chosen_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            taken_reg   <= taken_next;
            last_reg    <= last_next;
            ctr_reg     <= ctr_next;
            chosen_reg  <= chosen_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign clear_busy = (state_reg == ST_CLEAR);
    assign m_valid    = m_valid_reg;
    assign res        = res_reg;
    // counters only move when a new beat is loaded, so they match the held beat
    assign total_cnt  = total_reg;
    assign taken_cnt  = taken_reg;
    assign last_cnt   = last_reg;
    assign ctr_cnt    = ctr_reg;
    assign chosen_cnt = chosen_reg;

endmodule

FILE: rtl/core/tournament_branch_predictor.sv
// Tournament branch predictor: last-outcome bit, 2-bit counter and 2-bit
// chooser per entry of a direct-mapped, tagged table.
// Input channel (s_*): one resolved branch per beat, address and outcome.
// Result channel (m_*): one beat per input beat, in order: the three guesses,
// the hybrid miss flag and the saturating statistics after this branch.
// Branches outside [range_low, range_high] leave all state alone and return
// zero flags with the current counts.
// Config: cfg_wr_en/cfg_index/cfg_wdata, index 0 range_low, 1 range_high;
// write only while no branch is in flight.
// Path: the input beat passes the front queue, then the registered table read,
// then the result register. The back end pops no new branch until the table
// read-modify-write (registered read, then update) of the last one is done.
// Reset: aresetn low clears counters and queue and opens the range to all
// addresses; then a clearing pass wipes the table valid bits, s_ready low.
// Stall: the result holds while m_ready is low; the 2-beat queue keeps
// taking branches until full. TABLE_ENTRIES must be a power of two.
module tournament_branch_predictor import tbp_pkg::*; #(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PC_BITS-1:0]       s_branch_pc,
    input  logic                     s_taken,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_in_range,
    output logic                     m_pred_last,
    output logic                     m_pred_counter,
    output logic                     m_pred_chosen,
    output logic                     m_chosen_miss,
    output logic [STAT_BITS-1:0]     m_branch_count,
    output logic [STAT_BITS-1:0]     m_taken_count,
    output logic [STAT_BITS-1:0]     m_correct_last,
    output logic [STAT_BITS-1:0]     m_correct_counter,
    output logic [STAT_BITS-1:0]     m_correct_chosen,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    logic                  q_valid, q_pop, clear_busy;
    item_t                 q_item;
    result_t               res;
    logic [COUNT_BITS-1:0] total_cnt, taken_cnt, last_cnt, ctr_cnt, chosen_cnt;

    // front: range check and 2-deep queue
    tbp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_branch_pc (s_branch_pc),
        .s_taken     (s_taken),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .clear_busy  (clear_busy),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    // back: table lookup/update, statistics, result register
    tbp_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .res        (res),
        .total_cnt  (total_cnt),
        .taken_cnt  (taken_cnt),
        .last_cnt   (last_cnt),
        .ctr_cnt    (ctr_cnt),
        .chosen_cnt (chosen_cnt)
    );

    assign m_in_range     = res.in_range;
    assign m_pred_last    = res.pred_last;
    assign m_pred_counter = res.pred_counter;
    assign m_pred_chosen  = res.pred_chosen;
    assign m_chosen_miss  = res.chosen_miss;

    // low bits of each counter, zero-extended if the counters are narrower
    assign m_branch_count    = STAT_BITS'(total_cnt);
    assign m_taken_count     = STAT_BITS'(taken_cnt);
    assign m_correct_last    = STAT_BITS'(last_cnt);
    assign m_correct_counter = STAT_BITS'(ctr_cnt);
    assign m_correct_chosen  = STAT_BITS'(chosen_cnt);

endmodule

FILE: rtl/core/tbp_checker.sv
module tbp_sva import tbp_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic                     m_in_range,
    input logic                     m_pred_last,
    input logic                     m_pred_counter,
    input logic                     m_pred_chosen,
    input logic                     m_chosen_miss,
    input logic [STAT_BITS-1:0]     m_branch_count,
    input logic [STAT_BITS-1:0]     m_correct_chosen
);

    // table clearing pass follows reset: no input beat taken straight after
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input taken during table clear");

    // stalled result beat holds its statistics
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_branch_count) &&
                                $stable(m_correct_chosen))
        else $error("stalled result changed");

    // out-of-range beat carries no guesses
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> !m_pred_last && !m_pred_counter &&
                                   !m_pred_chosen && !m_chosen_miss)
        else $error("guess flags set for out-of-range branch");

    // hybrid guess is one of the two component guesses
    a_chosen_agrees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_in_range && (m_pred_last == m_pred_counter) |->
            m_pred_chosen == m_pred_last)
        else $error("hybrid guess differs from both components");

endmodule

bind tournament_branch_predictor tbp_sva u_tbp_sva (.*);
